### sv/dmm_pkg.sv
// dmm_pkg: shared types and constants of the dense matrix multiplier.
// Used by the channel interfaces, the RAM wrapper users and the top level.
// No dependencies.
package dmm_pkg;

  // Default largest matrix size (rows and columns held in the stores)
  localparam int MAX_N_DEFAULT = 16;

  // Field widths of the channels and the size register
  localparam int SIZE_W = 5;
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_WRITE_A  = 2'd0,
    OP_WRITE_B  = 2'd1,
    OP_MULTIPLY = 2'd2,
    OP_READ_C   = 2'd3
  } op_t;

endpackage

### sv/dmm_req_if.sv
// dmm_req_if: request channel of the matrix multiplier (valid/ready).
// Carries one element write, a multiply start or an element read.
// Depends on dmm_pkg.
interface dmm_req_if;
  logic                             valid;
  logic                             ready;
  dmm_pkg::op_t                     op;
  logic [dmm_pkg::IDX_W-1:0]        row;
  logic [dmm_pkg::IDX_W-1:0]        col;
  logic signed [dmm_pkg::ELEM_W-1:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

### sv/dmm_rsp_if.sv
// dmm_rsp_if: response channel of the matrix multiplier (valid/ready).
// Returns one element of C with its row and column.
// Depends on dmm_pkg.
interface dmm_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [dmm_pkg::IDX_W-1:0]        out_row;
  logic [dmm_pkg::IDX_W-1:0]        out_col;
  logic signed [dmm_pkg::ACC_W-1:0] product;

  modport source (output valid, out_row, out_col, product, input ready);
  modport sink   (input valid, out_row, out_col, product, output ready);
endinterface

### sv/dmm_ram.sv
// dmm_ram: generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// No dependencies.
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dense_matrix_multiply.sv
// dense_matrix_multiply: square integer matrix multiplier C = A * B.
// Depends on dmm_pkg, dmm_req_if, dmm_rsp_if and dmm_ram.
//
// The block holds three MAX_N x MAX_N matrices in synchronous RAMs: A and B
// (16-bit signed elements) and C (40-bit signed accumulators). A request
// either writes one element of A or B, starts the multiply, or reads one
// element of C; only a read returns a response. Sizes come from the
// size register (cfg_wen/cfg_wdata), saturated to MAX_N; writes
// outside the active n x n region are dropped and reads outside it return
// zero. A read drops ready on the request channel while the C RAM is read,
// and the response register is then loaded from the RAM data. A multiply
// first sweeps all of C to zero, one entry a cycle, then runs n*n*n
// multiply-accumulates in row, k, column order through a single MAC that
// reads A, B and C and writes C back, one MAC a cycle, and then drains its
// pipeline. The C RAM read/write port pair bounds the rate. After reset the
// same zero sweep of C runs with the request channel held off; configuration
// writes are taken throughout. A response waiting on the output register
// does not stall writes or a multiply; a second read is accepted but holds
// the request channel until the first response is transferred. A and B
// read as undefined until written.
module dense_matrix_multiply #(
  parameter int MAX_N = dmm_pkg::MAX_N_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [dmm_pkg::SIZE_W-1:0] cfg_wdata,
  dmm_req_if.sink                    req,
  dmm_rsp_if.source                  rsp
);

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_N);
  localparam int NW    = $clog2(MAX_N + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MAC,
    ST_DRAIN,
    ST_READ
  } state_t;

  // Row-major element address
  function automatic logic [AW-1:0] elem_addr(input logic [AW-1:0] r,
                                              input logic [AW-1:0] c);
    return AW'(r * MAX_N + c);
  endfunction

  state_t                            state;
  logic [dmm_pkg::SIZE_W-1:0]        size_reg;
  logic [NW-1:0]                     eff_n;
  logic [NW-1:0]                     n_last;

  logic [AW-1:0]                     clr_cnt;
  logic [IW-1:0]                     i_cnt, k_cnt, j_cnt;
  logic                              last_i, last_k, last_j;

  // MAC pipeline: S1 has RAM data, S2 has product and old C value
  logic                              s1_valid;
  logic [AW-1:0]                     s1_addr;
  logic                              s2_valid;
  logic [AW-1:0]                     s2_addr;
  logic signed [dmm_pkg::ACC_W-1:0]  s2_c;
  logic signed [dmm_pkg::PROD_W-1:0] s2_prod;
  logic                              wr_valid;
  logic [AW-1:0]                     wr_addr;
  logic signed [dmm_pkg::ACC_W-1:0]  wr_data;
  logic signed [dmm_pkg::PROD_W-1:0] mac_prod;
  logic signed [dmm_pkg::ACC_W-1:0]  mac_sum;
  logic signed [dmm_pkg::ACC_W-1:0]  c_fwd;

  // Pending element read and the response register
  logic [AW-1:0]                     rd_addr;
  logic [dmm_pkg::IDX_W-1:0]         rd_row, rd_col;
  logic                              rd_inside;
  logic                              rsp_valid;
  logic [dmm_pkg::IDX_W-1:0]         rsp_row, rsp_col;
  logic signed [dmm_pkg::ACC_W-1:0]  rsp_product;

  // Request decode
  logic                              req_fire;
  logic [AW-1:0]                     req_addr;
  logic                              req_inside;

  // RAM ports
  logic                              a_we, b_we, c_we;
  logic [AW-1:0]                     a_raddr, b_raddr, c_raddr, c_waddr;
  logic [dmm_pkg::ELEM_W-1:0]        a_rdata, b_rdata;
  logic [dmm_pkg::ACC_W-1:0]         c_rdata, c_wdata;
  logic                              clearing;

  // Effective size: saturate the register to MAX_N
  always_comb begin
    if (32'(size_reg) > MAX_N) begin
      eff_n = NW'(MAX_N);
    end else begin
      eff_n = NW'(size_reg);
    end
  end
  assign n_last = eff_n - 1'b1;

  assign req.ready  = (state == ST_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign req_addr   = elem_addr(AW'(req.row), AW'(req.col));
  assign req_inside = (32'(req.row) < 32'(eff_n)) && (32'(req.col) < 32'(eff_n));

  assign a_we = req_fire && (req.op == dmm_pkg::OP_WRITE_A) && req_inside;
  assign b_we = req_fire && (req.op == dmm_pkg::OP_WRITE_B) && req_inside;

  // Loop indices of the MAC sequence
  assign last_i = (NW'(i_cnt) == n_last);
  assign last_k = (NW'(k_cnt) == n_last);
  assign last_j = (NW'(j_cnt) == n_last);

  assign a_raddr = elem_addr(AW'(i_cnt), AW'(k_cnt));
  assign b_raddr = elem_addr(AW'(k_cnt), AW'(j_cnt));

  always_comb begin
    case (state)
      ST_MAC:  c_raddr = elem_addr(AW'(i_cnt), AW'(j_cnt));
      ST_READ: c_raddr = rd_addr;
      default: c_raddr = req_addr;
    endcase
  end

  // S1: multiply and pick the freshest C value. The entry may still be in
  // flight in S2 (sum not yet written) or written on the last edge, which
  // the read-old RAM missed.
  assign mac_prod = $signed(a_rdata) * $signed(b_rdata);
  assign mac_sum  = s2_c + dmm_pkg::ACC_W'(s2_prod);

  always_comb begin
    if (s2_valid && (s2_addr == s1_addr)) begin
      c_fwd = mac_sum;
    end else if (wr_valid && (wr_addr == s1_addr)) begin
      c_fwd = wr_data;
    end else begin
      c_fwd = $signed(c_rdata);
    end
  end

  // C write port: zero sweep or MAC write-back
  assign clearing = (state == ST_INIT) || (state == ST_CLEAR);
  assign c_we     = clearing || s2_valid;
  assign c_waddr  = clearing ? clr_cnt : s2_addr;
  assign c_wdata  = clearing ? '0 : mac_sum;

  dmm_ram #(.WIDTH(dmm_pkg::ELEM_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (req_addr),
    .wdata (req.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dmm_ram #(.WIDTH(dmm_pkg::ELEM_W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (req_addr),
    .wdata (req.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  dmm_ram #(.WIDTH(dmm_pkg::ACC_W), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      size_reg    <= dmm_pkg::SIZE_RESET;
      clr_cnt     <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      wr_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        size_reg <= cfg_wdata;
      end

      // Advance the MAC pipeline
      s1_valid <= (state == ST_MAC);
      s1_addr  <= elem_addr(AW'(i_cnt), AW'(j_cnt));
      s2_valid <= s1_valid;
      s2_addr  <= s1_addr;
      s2_c     <= c_fwd;
      s2_prod  <= mac_prod;
      wr_valid <= s2_valid;
      wr_addr  <= s2_addr;
      wr_data  <= mac_sum;

      // Drop the response once transferred
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_INIT, ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            clr_cnt <= '0;
            i_cnt   <= '0;
            k_cnt   <= '0;
            j_cnt   <= '0;
            if ((state == ST_CLEAR) && (eff_n != '0)) begin
              state <= ST_MAC;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            case (req.op)
              dmm_pkg::OP_MULTIPLY: begin
                state <= ST_CLEAR;
              end
              dmm_pkg::OP_READ_C: begin
                rd_addr   <= req_addr;
                rd_row    <= req.row;
                rd_col    <= req.col;
                rd_inside <= req_inside;
                state     <= ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAC: begin
          if (last_j) begin
            j_cnt <= '0;
            if (last_k) begin
              k_cnt <= '0;
              i_cnt <= i_cnt + 1'b1;
            end else begin
              k_cnt <= k_cnt + 1'b1;
            end
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
          if (last_i && last_k && last_j) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Hold until the last write-back has reached the RAM
          if (!s1_valid && !s2_valid) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          // RAM data holds while the read address holds; load when free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_row     <= rd_row;
            rsp_col     <= rd_col;
            rsp_product <= rd_inside ? $signed(c_rdata) : '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.out_row = rsp_row;
  assign rsp.out_col = rsp_col;
  assign rsp.product = rsp_product;

endmodule

### tb/tb_dense_matrix_multiply.sv
`timescale 1ns / 1ps
// tb_dense_matrix_multiply: self-checking testbench of the dense matrix multiplier.
// Depends on dmm_pkg, dmm_req_if, dmm_rsp_if and dense_matrix_multiply.
module tb_dense_matrix_multiply;

  localparam int MAX_N = dmm_pkg::MAX_N_DEFAULT;
  // A multiply keeps the request channel busy for a C sweep plus n^3 MACs.
  // Allow several of the slowest ones before calling the block hung.
  localparam int WATCHDOG_LIMIT = 4 * (MAX_N * MAX_N + MAX_N * MAX_N * MAX_N + 64);
  localparam logic signed [dmm_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [dmm_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

  typedef struct packed {
    dmm_pkg::op_t                      op;
    logic [dmm_pkg::IDX_W-1:0]         row;
    logic [dmm_pkg::IDX_W-1:0]         col;
    logic signed [dmm_pkg::ELEM_W-1:0] value;
  } dmm_request_t;

  typedef struct packed {
    logic [dmm_pkg::IDX_W-1:0]        row;
    logic [dmm_pkg::IDX_W-1:0]        col;
    logic signed [dmm_pkg::ACC_W-1:0] product;
  } c_read_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wen;
  logic [dmm_pkg::SIZE_W-1:0] cfg_wdata;

  dmm_req_if req_ch ();
  dmm_rsp_if rsp_ch ();

  dense_matrix_multiply #(
    .MAX_N(MAX_N)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #1 clk = ~clk;

  // Predicted contents of the three matrices and the size register.
  logic signed [dmm_pkg::ELEM_W-1:0] a_mat [MAX_N][MAX_N];
  logic signed [dmm_pkg::ELEM_W-1:0] b_mat [MAX_N][MAX_N];
  logic signed [dmm_pkg::ACC_W-1:0]  c_mat [MAX_N][MAX_N];
  logic [dmm_pkg::SIZE_W-1:0]        size_shadow;

  // Stimulus bookkeeping: which operand entries hold a written value.
  bit a_loaded [MAX_N][MAX_N];
  bit b_loaded [MAX_N][MAX_N];

  dmm_request_t request_queue[$];
  c_read_t      c_reads_due[$];
  dmm_request_t cur_item;
  c_read_t      got_due;

  int  queued_total   = 0;
  int  accepted_total = 0;
  int  mismatches     = 0;
  int  stall_cycles   = 0;
  int  send_gap       = 0;
  int  hold_ready     = 0;
  bit  slot_full      = 1'b0;
  bit  item_taken     = 1'b0;
  bit  idling         = 1'b1;

  // Effective size: the register value saturated to MAX_N.
  function automatic int active_size(input logic [dmm_pkg::SIZE_W-1:0] s);
    return (s > MAX_N) ? MAX_N : int'(s);
  endfunction

  // Apply one accepted request to the predicted matrices; a read of C
  // queues the element it must return.
  task automatic apply_request(input dmm_request_t item);
    int                               n;
    int                               i;
    int                               k;
    int                               j;
    bit                               in_region;
    logic signed [dmm_pkg::ACC_W-1:0] term;
    c_read_t                          due;
    n = active_size(size_shadow);
    in_region = (item.row < n) && (item.col < n);
    case (item.op)
      dmm_pkg::OP_WRITE_A: begin
        if (in_region) a_mat[item.row][item.col] = item.value;
      end
      dmm_pkg::OP_WRITE_B: begin
        if (in_region) b_mat[item.row][item.col] = item.value;
      end
      dmm_pkg::OP_MULTIPLY: begin
        // Clear all of C, then accumulate in row, k, column order.
        for (i = 0; i < MAX_N; i++)
          for (j = 0; j < MAX_N; j++)
            c_mat[i][j] = '0;
        for (i = 0; i < n; i++)
          for (k = 0; k < n; k++)
            for (j = 0; j < n; j++) begin
              term = a_mat[i][k] * b_mat[k][j];
              c_mat[i][j] = c_mat[i][j] + term;
            end
      end
      default: begin
        due.row = item.row;
        due.col = item.col;
        due.product = in_region ? c_mat[item.row][item.col] : '0;
        c_reads_due.push_back(due);
      end
    endcase
  endtask

  function automatic int pick_index(input int n);
    // Mostly stay inside the active region; now and then go anywhere.
    if (n == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, MAX_N - 1);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic logic signed [dmm_pkg::ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return '1;
      default: return dmm_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // Append one request to the pending queue and track operand writes
  // that land inside the active region.
  task automatic queue_request(input dmm_pkg::op_t op, input int r, input int c,
                               input logic signed [dmm_pkg::ELEM_W-1:0] v);
    dmm_request_t item;
    int           n;
    n = active_size(size_shadow);
    item.op = op;
    item.row = r[dmm_pkg::IDX_W-1:0];
    item.col = c[dmm_pkg::IDX_W-1:0];
    item.value = v;
    if (r < n && c < n) begin
      if (op == dmm_pkg::OP_WRITE_A) a_loaded[r][c] = 1'b1;
      if (op == dmm_pkg::OP_WRITE_B) b_loaded[r][c] = 1'b1;
    end
    request_queue.push_back(item);
    queued_total++;
  endtask

  // Write every operand entry of the n x n region not written yet, so a
  // multiply never reads an undefined element.
  task automatic fill_operands(input int n);
    int r;
    int c;
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        if (!a_loaded[r][c]) queue_request(dmm_pkg::OP_WRITE_A, r, c, pick_value());
        if (!b_loaded[r][c]) queue_request(dmm_pkg::OP_WRITE_B, r, c, pick_value());
      end
  endtask

  // Write the size register; only called while the block is idle.
  task automatic set_size(input logic [dmm_pkg::SIZE_W-1:0] s);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= s;
    size_shadow = s;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Wait until every request is transferred and every C read returned,
  // then hold long enough for a trailing multiply to drain.
  task automatic finish_phase();
    int n;
    do @(negedge clk);
    while (accepted_total != queued_total || c_reads_due.size() != 0);
    n = active_size(size_shadow);
    repeat (MAX_N * MAX_N + n * n * n + 16) @(posedge clk);
  endtask

  // One phase of random requests at a given size.
  task automatic random_phase(input logic [dmm_pkg::SIZE_W-1:0] s, input int count,
                              input bit idle);
    int n;
    set_size(s);
    idling = idle;
    n = active_size(s);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: queue_request(dmm_pkg::OP_WRITE_A, pick_index(n), pick_index(n),
                               pick_value());
        3, 4, 5: queue_request(dmm_pkg::OP_WRITE_B, pick_index(n), pick_index(n),
                               pick_value());
        6: begin
          fill_operands(n);
          queue_request(dmm_pkg::OP_MULTIPLY, $urandom_range(0, MAX_N - 1),
                        $urandom_range(0, MAX_N - 1), pick_value());
        end
        default: queue_request(dmm_pkg::OP_READ_C, pick_index(n), pick_index(n),
                               pick_value());
      endcase
    end
    finish_phase();
  endtask

  // Request driver: present the next pending item at the falling edge,
  // hold it until transferred, and, while idling is enabled, insert idle bursts between items.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (item_taken) begin
        item_taken = 1'b0;
        slot_full = 1'b0;
      end
      if (!slot_full) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          cur_item = request_queue.pop_front();
          slot_full = 1'b1;
          req_ch.op <= cur_item.op;
          req_ch.row <= cur_item.row;
          req_ch.col <= cur_item.col;
          req_ch.value <= cur_item.value;
          req_ch.valid <= 1'b1;
          if (idling && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Request transfer: predict its effect as the block takes it.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      apply_request(cur_item);
      accepted_total++;
      item_taken = 1'b1;
    end
  end

  // Response sink: drop ready in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_ready > 0) begin
      hold_ready--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (idling && $urandom_range(0, 9) == 0) hold_ready = $urandom_range(1, 17);
    end
  end

  // Response monitor: compare each transfer with the oldest pending C read.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (c_reads_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected C read response: row %0d col %0d product %0d",
                   rsp_ch.out_row, rsp_ch.out_col, rsp_ch.product);
      end else begin
        got_due = c_reads_due.pop_front();
        if (rsp_ch.out_row !== got_due.row || rsp_ch.out_col !== got_due.col ||
            rsp_ch.product !== got_due.product) begin
          mismatches++;
          if (mismatches <= 10)
            $display("C read mismatch: expected (%0d,%0d) %0d, got (%0d,%0d) %0d",
                     got_due.row, got_due.col, got_due.product,
                     rsp_ch.out_row, rsp_ch.out_col, rsp_ch.product);
        end
      end
    end
  end

  // Count cycles with work outstanding but no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (accepted_total == queued_total && c_reads_due.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int r;
    int c;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.op = dmm_pkg::OP_WRITE_A;
    req_ch.row = '0;
    req_ch.col = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    size_shadow = dmm_pkg::SIZE_RESET;
    for (r = 0; r < MAX_N; r++)
      for (c = 0; c < MAX_N; c++) begin
        a_mat[r][c] = '0;
        b_mat[r][c] = '0;
        c_mat[r][c] = '0;
      end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full size at its reset value: C reads zero before any multiply.
    queue_request(dmm_pkg::OP_READ_C, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, MAX_N - 1, MAX_N - 1, '0);
    queue_request(dmm_pkg::OP_WRITE_A, MAX_N - 1, MAX_N - 1, ELEM_MAX);
    queue_request(dmm_pkg::OP_READ_C, 7, 9, '0);
    finish_phase();

    // Extreme operands at size 3: row 0 of A and column 0 of B at the most
    // negative value, the last column of B at the most positive one.
    set_size(5'd3);
    for (c = 0; c < 3; c++) queue_request(dmm_pkg::OP_WRITE_A, 0, c, ELEM_MIN);
    for (r = 0; r < 3; r++) begin
      queue_request(dmm_pkg::OP_WRITE_B, r, 0, ELEM_MIN);
      queue_request(dmm_pkg::OP_WRITE_B, r, 2, ELEM_MAX);
    end
    fill_operands(3);
    queue_request(dmm_pkg::OP_MULTIPLY, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, 0, 2, '0);
    queue_request(dmm_pkg::OP_READ_C, 2, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, 2, 2, '0);
    queue_request(dmm_pkg::OP_READ_C, 3, 3, '0);
    queue_request(dmm_pkg::OP_READ_C, MAX_N - 1, MAX_N - 1, '0);
    finish_phase();

    // Size one: writes and reads inside and outside the 1 x 1 region.
    set_size(5'd1);
    queue_request(dmm_pkg::OP_WRITE_A, 0, 0, ELEM_MIN);
    queue_request(dmm_pkg::OP_WRITE_B, 0, 0, ELEM_MIN);
    queue_request(dmm_pkg::OP_WRITE_A, 3, 2, 16'sd5);
    queue_request(dmm_pkg::OP_WRITE_B, 0, 1, ELEM_MAX);
    queue_request(dmm_pkg::OP_MULTIPLY, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, 0, 1, '0);
    queue_request(dmm_pkg::OP_READ_C, MAX_N - 1, MAX_N - 1, '0);
    finish_phase();

    // Size zero: writes dropped, multiply only clears C.
    set_size(5'd0);
    queue_request(dmm_pkg::OP_WRITE_A, 0, 0, 16'sd7);
    queue_request(dmm_pkg::OP_MULTIPLY, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, 0, 0, '0);
    finish_phase();

    // Largest register value saturates to MAX_N: every index is inside the
    // region, and C reads back cleared.
    set_size(5'd31);
    queue_request(dmm_pkg::OP_READ_C, 0, 0, '0);
    queue_request(dmm_pkg::OP_READ_C, MAX_N - 1, MAX_N - 1, '0);
    queue_request(dmm_pkg::OP_WRITE_A, MAX_N - 1, MAX_N - 1, '1);
    queue_request(dmm_pkg::OP_READ_C, MAX_N - 1, MAX_N - 1, '0);
    queue_request(dmm_pkg::OP_READ_C, 0, MAX_N - 1, '0);
    finish_phase();

    // Random phases over small and degenerate sizes; the last one runs
    // with no idling on either side.
    random_phase(dmm_pkg::SIZE_W'($urandom_range(1, 4)), 20, $urandom_range(0, 3) != 0);
    random_phase(dmm_pkg::SIZE_W'($urandom_range(0, 3)), 20, 1'b1);
    random_phase(dmm_pkg::SIZE_W'($urandom_range(2, 4)), 20, $urandom_range(0, 3) != 0);
    random_phase(dmm_pkg::SIZE_W'($urandom_range(1, 4)), 20, 1'b0);

    if (mismatches == 0 && c_reads_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
